@@ src/rlex_pkg.sv @@
// Shared types and constants for the run/suite segment encoder.
// No dependencies; imported by every module of the block.
package rlex_pkg;

  localparam int MAX_PIXELS = 65536;
  localparam int FIFO_DEPTH = 4;

  // count field size classes
  localparam logic [1:0] SIZE_BYTE = 2'd0;
  localparam logic [1:0] SIZE_U16  = 2'd1;
  localparam logic [1:0] SIZE_U32  = 2'd2;

  localparam logic [15:0] REPEAT_MAX = 16'hFFFF;
  localparam logic [15:0] SIZE1_LIM  = 16'h00FF;

  // register indexes (paddr[3:2])
  localparam logic [1:0] REG_STOP_BITS     = 2'd0;
  localparam logic [1:0] REG_PALETTE_COUNT = 2'd1;
  localparam logic [1:0] REG_AREA_PIXELS   = 2'd2;

  typedef struct packed {
    logic [2:0]  stop_bits;
    logic [6:0]  palette_count;
    logic [16:0] area_pixels;
  } cfg_t;

  typedef struct packed {
    logic [7:0]  code_byte;
    logic [15:0] repeat_count;
    logic [1:0]  count_size;
    logic        too_large;
    logic        final_res;
  } res_t;

  typedef struct packed {
    res_t        res;
    logic [17:0] total;
    logic        big;
  } emit_t;

endpackage

@@ src/rlex_cfg.sv @@
// APB-style register file: stop_bits, palette_count, area_pixels.
// Depends on rlex_pkg.
module rlex_cfg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [3:0]          cfg_paddr,
  input  logic [31:0]         cfg_pwdata,
  output logic [31:0]         cfg_prdata,
  output logic                cfg_pready,
  output rlex_pkg::cfg_t      cfg
);
  import rlex_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;
  logic wr_en;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg        = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (cfg_paddr[3:2])
        REG_STOP_BITS:     cfg_nxt.stop_bits     = cfg_pwdata[2:0];
        REG_PALETTE_COUNT: cfg_nxt.palette_count = cfg_pwdata[6:0];
        REG_AREA_PIXELS:   cfg_nxt.area_pixels   = cfg_pwdata[16:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[3:2])
      REG_STOP_BITS:     cfg_prdata = {29'd0, cfg_r.stop_bits};
      REG_PALETTE_COUNT: cfg_prdata = {25'd0, cfg_r.palette_count};
      REG_AREA_PIXELS:   cfg_prdata = {15'd0, cfg_r.area_pixels};
      default:           cfg_prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{stop_bits: 3'd1, palette_count: 7'd1, area_pixels: 17'd1};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

@@ src/rlex_core.sv @@
// Input register, segment state and per-word encode logic (up to two results).
// Depends on rlex_pkg.
module rlex_core (
  input  logic           clk,
  input  logic           rst_n,
  input  rlex_pkg::cfg_t cfg,
  input  logic           in_valid,
  output logic           in_stall,
  input  logic [6:0]     in_palette_index,
  input  logic           in_end_of_area,
  input  logic           space_ok,
  output logic           push0,
  output logic           push1,
  output rlex_pkg::res_t res0,
  output rlex_pkg::res_t res1
);
  import rlex_pkg::*;

  function automatic emit_t emit_f(input logic [6:0] st, input logic [6:0] sp,
                                   input logic [15:0] rp, input logic [17:0] bt,
                                   input logic [2:0] bits, input logic [18:0] lim,
                                   input logic fin);
    logic [6:0]  depth;
    logic [7:0]  code;
    logic [1:0]  size;
    logic [3:0]  add;
    logic [18:0] sum;
    emit_t       e;
    depth = sp - st;
    code  = 8'({1'b0, depth} << bits) | {1'b0, sp};
    if (rp < SIZE1_LIM) begin
      size = SIZE_BYTE; add = 4'd2;
    end else if (rp < REPEAT_MAX) begin
      size = SIZE_U16;  add = 4'd4;
    end else begin
      size = SIZE_U32;  add = 4'd8;
    end
    sum     = {1'b0, bt} + {15'd0, add};
    e.total = sum[18] ? 18'h3FFFF : sum[17:0];
    e.big   = {1'b0, e.total} > lim;
    if (e.big) begin
      e.res = '{code_byte: 8'd0, repeat_count: 16'd0, count_size: SIZE_BYTE,
                too_large: 1'b1, final_res: 1'b1};
    end else begin
      e.res = '{code_byte: code, repeat_count: rp, count_size: size,
                too_large: 1'b0, final_res: fin};
    end
    return e;
  endfunction

  // input register
  logic       item_v_r;
  logic [6:0] idx_r;
  logic       last_r;
  logic       go;
  logic       take;

  // segment state
  logic [6:0]  seg_start_r, seg_start_nxt;
  logic [6:0]  seg_stop_r,  seg_stop_nxt;
  logic [15:0] repeats_r,   repeats_nxt;
  logic        in_suite_r,  in_suite_nxt;
  logic        have_seg_r,  have_seg_nxt;
  logic [17:0] byte_total_r, byte_total_nxt;
  logic        aborted_r,   aborted_nxt;

  logic [16:0] area_eff;
  logic [18:0] limit;
  logic [17:0] header;
  logic [6:0]  depth;
  logic [8:0]  depth_cap;
  emit_t       ea, eb;
  logic        done;

  assign go       = item_v_r & space_ok;
  assign in_stall = item_v_r & ~space_ok;
  assign take     = in_valid & ~in_stall;

  assign area_eff  = (cfg.area_pixels > 17'(MAX_PIXELS)) ? 17'(MAX_PIXELS)
                                                         : cfg.area_pixels;
  assign limit     = {2'b0, area_eff} + {1'b0, area_eff, 1'b0};
  assign header    = 18'({cfg.palette_count, 1'b0}) + 18'(cfg.palette_count) + 18'd1;
  assign depth     = seg_stop_r - seg_start_r;
  assign depth_cap = (9'd1 << (4'd8 - {1'b0, cfg.stop_bits})) - 9'd1;

  always_comb begin
    seg_start_nxt  = seg_start_r;
    seg_stop_nxt   = seg_stop_r;
    repeats_nxt    = repeats_r;
    in_suite_nxt   = in_suite_r;
    have_seg_nxt   = have_seg_r;
    byte_total_nxt = byte_total_r;
    aborted_nxt    = aborted_r;
    push0 = 1'b0;
    push1 = 1'b0;
    res0  = '0;
    res1  = '0;
    done  = 1'b0;
    ea = emit_f(seg_start_r, seg_stop_r, repeats_r, byte_total_r,
                cfg.stop_bits, limit, 1'b0);
    eb = '0;
    if (go) begin
      if (aborted_r) begin
        done = 1'b1;
        if (last_r) begin
          aborted_nxt    = 1'b0;
          byte_total_nxt = '0;
        end
      end else if (!have_seg_r) begin
        byte_total_nxt = header;
        seg_start_nxt  = idx_r;
        seg_stop_nxt   = idx_r;
        repeats_nxt    = '0;
        in_suite_nxt   = 1'b0;
        have_seg_nxt   = 1'b1;
      end else if (!in_suite_r && idx_r == seg_start_r && repeats_r != REPEAT_MAX) begin
        repeats_nxt = repeats_r + 16'd1;
      end else if ({1'b0, idx_r} == {1'b0, seg_stop_r} + 8'd1
                   && {2'b0, depth} < depth_cap) begin
        seg_stop_nxt = idx_r;
        in_suite_nxt = 1'b1;
      end else begin
        // close held segment
        push0 = 1'b1;
        res0  = ea.res;
        byte_total_nxt = ea.total;
        if (ea.big) begin
          done         = 1'b1;
          aborted_nxt  = ~last_r;
          have_seg_nxt = 1'b0;
        end else begin
          seg_start_nxt = idx_r;
          seg_stop_nxt  = idx_r;
          repeats_nxt   = '0;
          in_suite_nxt  = 1'b0;
        end
      end
      if (last_r && !done) begin
        eb = emit_f(seg_start_nxt, seg_stop_nxt, repeats_nxt, byte_total_nxt,
                    cfg.stop_bits, limit, 1'b1);
        if (push0) begin
          push1 = 1'b1;
          res1  = eb.res;
        end else begin
          push0 = 1'b1;
          res0  = eb.res;
        end
      end
      if (last_r) begin
        seg_start_nxt  = '0;
        seg_stop_nxt   = '0;
        repeats_nxt    = '0;
        in_suite_nxt   = 1'b0;
        have_seg_nxt   = 1'b0;
        byte_total_nxt = '0;
        aborted_nxt    = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_v_r     <= 1'b0;
      seg_start_r  <= '0;
      seg_stop_r   <= '0;
      repeats_r    <= '0;
      in_suite_r   <= 1'b0;
      have_seg_r   <= 1'b0;
      byte_total_r <= '0;
      aborted_r    <= 1'b0;
    end else begin
      if (take) begin
        item_v_r <= 1'b1;
      end else if (go) begin
        item_v_r <= 1'b0;
      end
      seg_start_r  <= seg_start_nxt;
      seg_stop_r   <= seg_stop_nxt;
      repeats_r    <= repeats_nxt;
      in_suite_r   <= in_suite_nxt;
      have_seg_r   <= have_seg_nxt;
      byte_total_r <= byte_total_nxt;
      aborted_r    <= aborted_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      idx_r  <= in_palette_index;
      last_r <= in_end_of_area;
    end
  end

endmodule

@@ src/rlex_fifo.sv @@
// Result queue: per cycle takes up to two words, gives one unless out_stall.
// Depends on rlex_pkg.
module rlex_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push0,
  input  logic           push1,
  input  rlex_pkg::res_t res0,
  input  rlex_pkg::res_t res1,
  output logic           space_ok,
  output logic           out_valid,
  input  logic           out_stall,
  output rlex_pkg::res_t out_res
);
  import rlex_pkg::*;

  localparam int PW = $clog2(FIFO_DEPTH);

  res_t          mem [FIFO_DEPTH];
  logic [PW-1:0] wr_r, rd_r;
  logic [PW:0]   cnt_r, cnt_nxt;
  logic          pop;
  logic [PW-1:0] wr1;

  assign pop       = out_valid & ~out_stall;
  assign out_valid = cnt_r != '0;
  assign out_res   = mem[rd_r];
  assign space_ok  = cnt_r <= (PW+1)'(FIFO_DEPTH - 2);
  assign wr1       = wr_r + PW'(1);
  assign cnt_nxt   = cnt_r + (PW+1)'(push0) + (PW+1)'(push1) - (PW+1)'(pop);

  always_ff @(posedge clk) begin
    if (push0) mem[wr_r] <= res0;
    if (push1) mem[wr1]  <= res1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_r + PW'(push0) + PW'(push1);
      rd_r  <= rd_r + PW'(pop);
      cnt_r <= cnt_nxt;
    end
  end

endmodule

@@ src/rlex_segment_encoder.sv @@
// Top level of the run/suite segment encoder: register file, core, result queue.
// Depends on rlex_pkg, rlex_cfg, rlex_core, rlex_fifo.
//
//  port group | direction | word
//  -----------+-----------+-------------------------------------------------
//  in_*       | input     | palette_index, end_of_area (one pixel)
//  out_*      | output    | code_byte, repeat_count, count_size, too_large,
//             |           | final_res (one segment)
//  cfg_*      | APB slave | stop_bits @0x0, palette_count @0x4, area_pixels @0x8
//
// One pixel word can be taken every cycle while in_stall is low. A word lands in
// the input register at its accepting edge and is encoded once the queue has room;
// its results (zero, one or two) are registered into a four-entry queue, whose
// head raises out_valid and drives the out_* ports.
// The input register only drains while the queue has room for two words, so
// a stalled output backs up into in_stall.
// Reset (rst_n low, synchronous) empties the queue, clears segment state and
// loads the registers with 1, 1, 1.
module rlex_segment_encoder (
  input  logic        clk,
  input  logic        rst_n,
  // pixel words
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [6:0]  in_palette_index,
  input  logic        in_end_of_area,
  // segment words
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_code_byte,
  output logic [15:0] out_repeat_count,
  output logic [1:0]  out_count_size,
  output logic        out_too_large,
  output logic        out_final_res,
  // configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import rlex_pkg::*;

  cfg_t cfg;
  logic space_ok;
  logic push0, push1;
  res_t res0, res1;
  res_t out_res;

  rlex_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  // segment tracking and byte accounting
  rlex_core u_core (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_palette_index (in_palette_index),
    .in_end_of_area   (in_end_of_area),
    .space_ok         (space_ok),
    .push0            (push0),
    .push1            (push1),
    .res0             (res0),
    .res1             (res1)
  );

  rlex_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push0     (push0),
    .push1     (push1),
    .res0      (res0),
    .res1      (res1),
    .space_ok  (space_ok),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign out_code_byte    = out_res.code_byte;
  assign out_repeat_count = out_res.repeat_count;
  assign out_count_size   = out_res.count_size;
  assign out_too_large    = out_res.too_large;
  assign out_final_res    = out_res.final_res;

endmodule
